>>> rtl/sha1md_pkg.sv
// Package with the SHA-1 constants and the sequencer state type.
`default_nettype none
package sha1md_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [2:0] LAST_WORD = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

endpackage
`default_nettype wire

>>> rtl/sha1_message_digest.sv
// SHA-1 digest over a byte stream with an iterative round unit and a padding sequencer.
// Message bytes are taken one per cycle in idle; a full 64-byte block is compressed
// (80 rounds of the single round unit, one chain update) before the next beat is taken.
// After the end beat the sequencer writes one padding byte per cycle (up to 72 bytes,
// plus one or two block compressions) and offers five digest beats, one per ready cycle.
// aresetn is synchronous and active low; it loads the initial vector and clears all counts.
`default_nettype none
module sha1_message_digest (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  wire logic [0:0]  s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_number
    output logic             m_tlast
);

    sha1md_pkg::state_t state_reg, state_next;

    logic [31:0] chain_reg [5];
    logic [31:0] win_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [23:0] acc_reg;
    logic [60:0] total_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  round_reg;
    logic [2:0]  word_reg;
    logic        pad_reg, first_reg, len_ok_reg;

    logic        s_fire, m_fire;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [63:0] bit_len;
    logic [5:0]  len_sh;
    logic [7:0]  len_byte;
    logic [31:0] f_val, k_val, t_val, w_new;

    assign s_tready = (state_reg == sha1md_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sha1md_pkg::ST_OUT);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = chain_reg[word_reg];
    assign m_tuser  = word_reg;
    assign m_tlast  = (word_reg == sha1md_pkg::LAST_WORD);

    assign bit_len  = {total_reg, 3'b000};
    assign len_sh   = {3'(3'd7 - pos_reg[2:0]), 3'b000};
    assign len_byte = 8'(bit_len >> len_sh);

    always_comb begin
        wr_en   = 1'b0;
        wr_byte = s_tdata;
        if (state_reg == sha1md_pkg::ST_IDLE) begin
            wr_en = s_fire && s_tuser[0];
        end else if (state_reg == sha1md_pkg::ST_PAD) begin
            wr_en = 1'b1;
            if (first_reg) begin
                wr_byte = sha1md_pkg::PAD_MARK;
            end else if (len_ok_reg && (pos_reg >= sha1md_pkg::LEN_POS)) begin
                wr_byte = len_byte;
            end else begin
                wr_byte = 8'h00;
            end
        end
    end

    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + win_reg[0];
        w_new = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE: begin
                if (wr_en && (pos_reg == 6'd63)) begin
                    state_next = sha1md_pkg::ST_ROUND;
                end else if (s_fire && s_tlast) begin
                    state_next = sha1md_pkg::ST_PAD;
                end
            end
            sha1md_pkg::ST_PAD: begin
                if (pos_reg == 6'd63) begin
                    state_next = sha1md_pkg::ST_ROUND;
                end
            end
            sha1md_pkg::ST_ROUND: begin
                if (round_reg == sha1md_pkg::LAST_ROUND) begin
                    state_next = sha1md_pkg::ST_FINISH;
                end
            end
            sha1md_pkg::ST_FINISH: begin
                if (!pad_reg) begin
                    state_next = sha1md_pkg::ST_IDLE;
                end else if (!first_reg && len_ok_reg) begin
                    state_next = sha1md_pkg::ST_OUT;
                end else begin
                    state_next = sha1md_pkg::ST_PAD;
                end
            end
            sha1md_pkg::ST_OUT: begin
                if (m_fire && m_tlast) begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end
            default: state_next = sha1md_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1md_pkg::ST_IDLE;
            chain_reg[0] <= sha1md_pkg::IV0;
            chain_reg[1] <= sha1md_pkg::IV1;
            chain_reg[2] <= sha1md_pkg::IV2;
            chain_reg[3] <= sha1md_pkg::IV3;
            chain_reg[4] <= sha1md_pkg::IV4;
            total_reg    <= '0;
            pos_reg      <= '0;
            round_reg    <= '0;
            word_reg     <= '0;
            pad_reg      <= 1'b0;
            first_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire && s_tlast) begin
                pad_reg   <= 1'b1;
                first_reg <= 1'b1;
            end
            if (wr_en) begin
                pos_reg <= pos_reg + 6'd1;
                if (state_reg == sha1md_pkg::ST_IDLE) begin
                    total_reg <= total_reg + 61'd1;
                end
                if (state_reg == sha1md_pkg::ST_PAD && first_reg) begin
                    first_reg <= 1'b0;
                    if (pos_reg < sha1md_pkg::LEN_POS) begin
                        len_ok_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == sha1md_pkg::ST_ROUND) begin
                if (round_reg == sha1md_pkg::LAST_ROUND) begin
                    round_reg <= '0;
                end else begin
                    round_reg <= round_reg + 7'd1;
                end
            end
            if (state_reg == sha1md_pkg::ST_FINISH) begin
                round_reg    <= '0;
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
                if (pad_reg && !first_reg) begin
                    len_ok_reg <= 1'b1;
                end
            end
            if (m_fire) begin
                word_reg <= word_reg + 3'd1;
                if (m_tlast) begin
                    word_reg     <= '0;
                    chain_reg[0] <= sha1md_pkg::IV0;
                    chain_reg[1] <= sha1md_pkg::IV1;
                    chain_reg[2] <= sha1md_pkg::IV2;
                    chain_reg[3] <= sha1md_pkg::IV3;
                    chain_reg[4] <= sha1md_pkg::IV4;
                    total_reg    <= '0;
                    pos_reg      <= '0;
                    pad_reg      <= 1'b0;
                    first_reg    <= 1'b0;
                    len_ok_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            acc_reg <= {acc_reg[15:0], wr_byte};
            if (pos_reg[1:0] == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[15] <= {acc_reg, wr_byte};
            end
            if (pos_reg == 6'd63) begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
        end
        if (state_reg == sha1md_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while digest is offered");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= sha1md_pkg::LAST_ROUND)
        else $error("round counter out of range");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha1md_pkg::ST_ROUND && round_reg == sha1md_pkg::LAST_ROUND)
        |=> (state_reg == sha1md_pkg::ST_FINISH))
        else $error("compression did not end after the last round");

    a_word_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (word_reg <= sha1md_pkg::LAST_WORD))
        else $error("digest word index out of range");

    a_out_after_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pad_reg && len_ok_reg && !first_reg))
        else $error("digest offered before padding finished");

endmodule
`default_nettype wire

>>> bench/sha1_digest_checker.sv
// Checker that predicts SHA-1 digests from the input beats and compares the output beats.
`timescale 1ns / 100ps
module sha1_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] digest_word
    input  logic [2:0]  m_tuser,   // [2:0] word_number
    input  logic        m_tlast,
    output int          beats_due,
    output int          mismatch_count
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  number;
        logic        last;
    } digest_beat_t;

    localparam logic [159:0] INIT_CHAIN = {sha1md_pkg::IV0, sha1md_pkg::IV1, sha1md_pkg::IV2,
                                           sha1md_pkg::IV3, sha1md_pkg::IV4};

    digest_beat_t digest_beats_due[$];
    logic [159:0] chain;
    logic [511:0] msg_block;
    logic [60:0]  byte_count;
    int           errors;

    initial begin
        beats_due = 0;
        mismatch_count = 0;
        errors = 0;
        chain = INIT_CHAIN;
        msg_block = '0;
        byte_count = '0;
    end

    function automatic logic [159:0] digest_compress(input logic [159:0] h,
                                                     input logic [511:0] blk);
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int r;
        for (r = 0; r < 16; r++) begin
            w[r] = blk[511 - 32 * r -: 32];
        end
        {a, b, c, d, e} = h;
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
                w[r & 15] = {x[30:0], x[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    always @(posedge aclk) begin : watch
        int pos;
        int i;
        digest_beat_t due;
        if (!aresetn) begin
            chain = INIT_CHAIN;
            msg_block = '0;
            byte_count = '0;
            digest_beats_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    pos = int'(byte_count[5:0]);
                    msg_block[511 - 8 * pos -: 8] = s_tdata;
                    byte_count = byte_count + 61'd1;
                    if (pos == 63) begin
                        chain = digest_compress(chain, msg_block);
                    end
                end
                if (s_tlast) begin
                    pos = int'(byte_count[5:0]);
                    msg_block[511 - 8 * pos -: 8] = sha1md_pkg::PAD_MARK;
                    for (i = pos + 1; i < 64; i++) begin
                        msg_block[511 - 8 * i -: 8] = 8'h00;
                    end
                    // No room for the length field, so the padding spills into a second block.
                    if (pos >= int'(sha1md_pkg::LEN_POS)) begin
                        chain = digest_compress(chain, msg_block);
                        msg_block = '0;
                    end
                    msg_block[63:0] = {byte_count, 3'b000};
                    chain = digest_compress(chain, msg_block);
                    for (i = 0; i < 5; i++) begin
                        due.word = chain[159 - 32 * i -: 32];
                        due.number = 3'(i);
                        due.last = (3'(i) == sha1md_pkg::LAST_WORD);
                        digest_beats_due.push_back(due);
                    end
                    chain = INIT_CHAIN;
                    byte_count = '0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (digest_beats_due.size() == 0) begin
                    $display("%0t: unexpected digest beat, got word %h number %0d last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    due = digest_beats_due.pop_front();
                    if (m_tdata !== due.word) begin
                        $display("%0t: digest word mismatch, expected %h, got %h",
                                 $time, due.word, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== due.number) begin
                        $display("%0t: word number mismatch, expected %0d, got %0d",
                                 $time, due.number, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== due.last) begin
                        $display("%0t: final word flag mismatch, expected %b, got %b",
                                 $time, due.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
        beats_due <= digest_beats_due.size();
        mismatch_count <= errors;
    end

endmodule

>>> bench/tb.sv
// Testbench top for the SHA-1 digest block: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] msg_byte
    logic [0:0]  s_tuser = 1'b0;    // [0] byte_present
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] digest_word
    logic [2:0]  m_tuser;           // [2:0] word_number
    logic        m_tlast;

    int beats_due;
    int mismatch_count;
    int burst_left = 0;
    bit steady = 1'b0;
    int items_sent = 0;
    int messages_sent = 0;
    int stall_mode = 0;
    int stall_span = 0;

    always #5 aclk = ~aclk;

    sha1_message_digest uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha1_digest_checker digest_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .beats_due      (beats_due),
        .mismatch_count (mismatch_count)
    );

    // The receiver switches between always ready, random stalls and frequent stalls.
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(20, 120);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady) begin
                gap = $urandom_range(0, 8);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= present;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_due != 0);
    endtask

    task automatic send_message(input int len, input bit end_on_byte);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        messages_sent++;
    endtask

    initial begin : stimulus
        int i;
        int len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        steady = 1'b1;
        send_beat(8'h5A, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        steady = 1'b0;
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        for (i = 0; i < 10; i++) begin
            send_beat((i % 2 == 0) ? 8'h55 : 8'hAA, 1'b1, 1'b0);
        end
        send_beat(8'h00, 1'b0, 1'b1);
        drain_digests();

        while (items_sent < 455 || messages_sent < 16) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    len = $urandom_range(0, 20);
                end
                5, 6, 7: begin
                    case ($urandom_range(0, 7))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        5: len = 65;
                        6: len = 119;
                        default: len = 120;
                    endcase
                end
                default: begin
                    len = $urandom_range(21, 140);
                end
            endcase
            steady = ($urandom_range(0, 3) == 0);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0) begin
                drain_digests();
            end
        end

        drain_digests();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && beats_due == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
